### rtl/rsi_pkg.sv
// shared constants for the ray / sphere intersection block
package rsi_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int DIR_WIDTH      = 16;
    localparam int DIR_FRAC       = 14;
    localparam int CFG_ADDR_WIDTH = 8;
    localparam int RADIUS_RESET   = 65536;

    // configuration register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_CENTER_X = 8'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_CENTER_Y = 8'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_CENTER_Z = 8'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RADIUS   = 8'd3;

endpackage

### rtl/rsi_square.sv
// pipelined squarer built from half-width partial products: registered partial products, then a registered wide add
module rsi_square #(
    parameter int WIDTH = rsi_pkg::COORD_WIDTH + 1
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WIDTH-1:0] i_a,
    output logic [2*WIDTH-1:0]      o_sq
);

    localparam int K  = WIDTH / 2;
    localparam int HW = WIDTH - K;
    localparam int SW = 2 * WIDTH + 2;

    logic signed [HW-1:0]   w_hi;
    logic signed [K:0]      w_lo;
    logic signed [2*HW-1:0] r_hh;
    logic signed [HW+K:0]   r_hl;
    logic [2*K-1:0]         r_ll;
    logic signed [SW-1:0]   n_sum;
    logic [2*WIDTH-1:0]     r_sq;

    assign w_hi = i_a[WIDTH-1:K];
    assign w_lo = $signed({1'b0, i_a[K-1:0]});

    // partial products, then one wide add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= w_hi * w_hi;
            r_hl <= w_hi * w_lo;
            r_ll <= i_a[K-1:0] * i_a[K-1:0];
            r_sq <= n_sum[2*WIDTH-1:0];
        end
    end

    always_comb begin
        n_sum = (SW'(r_hh) <<< (2 * K)) + (SW'(r_hl) <<< (K + 1))
              + $signed(SW'(r_ll));
    end

    assign o_sq = r_sq;

endmodule

### rtl/rsi_sqrt.sv
// pipelined integer square root, one result bit per stage
module rsi_sqrt #(
    parameter int SQW   = 2 * (rsi_pkg::COORD_WIDTH + 5),
    parameter int SIDEW = rsi_pkg::COORD_WIDTH + 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SQW-1:0]     i_rad,
    input  logic [SIDEW-1:0]   i_side,
    output logic               o_valid,
    output logic [SQW/2-1:0]   o_root,
    output logic [SIDEW-1:0]   o_side
);

    localparam int N = SQW / 2;

    logic [SQW-1:0]   r_x    [N];
    logic [SQW-1:0]   r_res  [N];
    logic [SIDEW-1:0] r_side [N];
    logic [N-1:0]     r_vld;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [SQW-1:0] ONE = SQW'(1) << (SQW - 2 - 2 * i);
        logic [SQW-1:0]   w_x;
        logic [SQW-1:0]   w_res;
        logic [SIDEW-1:0] w_side;
        logic             w_vld;
        logic [SQW-1:0]   w_trial;

        if (i == 0) begin : g_first
            assign w_x    = i_rad;
            assign w_res  = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_x    = r_x[i-1];
            assign w_res  = r_res[i-1];
            assign w_side = r_side[i-1];
            assign w_vld  = r_vld[i-1];
        end

        assign w_trial = w_res + ONE;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[i] <= w_side;
                if (w_x >= w_trial) begin
                    r_x[i]   <= w_x - w_trial;
                    r_res[i] <= (w_res >> 1) + ONE;
                end else begin
                    r_x[i]   <= w_x;
                    r_res[i] <= w_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_res[N-1][N-1:0];
    assign o_side  = r_side[N-1];

endmodule

### rtl/ray_sphere_intersection.sv
// top level of the ray / sphere intersection pipeline
//
// one ray enters on the s_axis channel per transfer: origin in signed q16.16,
// unit direction in signed q1.14. it is tested against the sphere held in the
// configuration registers (center x, y, z and radius, indexes 0 to 3 on the
// cfg write channel; cfg_ready is always high, other indexes are dropped).
// every ray gives exactly one result transfer on m_axis: tuser carries the hit
// flag, tdata the q16.16 distance, saturated, and the maximum on a miss.
// throughput is one ray per cycle while the receiver does not stall m_axis. a ray
// passes from the input transfer to m_axis through six stages of differences,
// products and squares, COORD_WIDTH + 5 square root stages (one root bit
// each, this is the long part) and the output register.
// the pipeline moves as one: when the result register is full and the
// receiver holds tready low, every stage holds and s_axis_tready drops, so
// nothing is lost or repeated. reset clears the valid bits and loads the
// center with 0 and the radius with 1.0; configuration must be written only
// while no ray is in flight, which the block itself does not enforce.
module ray_sphere_intersection #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rsi_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]             i_cfg_data,
    // rays in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
    input  logic [((3*COORD_WIDTH+3*rsi_pkg::DIR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // results out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hit_distance, zero fill
    output logic [((COORD_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
    // hit_found
    output logic [0:0]                         m_axis_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = rsi_pkg::DIR_WIDTH;
    localparam int VW    = W + 1;           // center - origin
    localparam int PW    = VW + DW;         // one dot product term
    localparam int AW    = PW + 2;          // dot product sum
    localparam int DVW   = AW - rsi_pkg::DIR_FRAC;
    localparam int VSW   = 2 * VW + 2;      // |v|^2
    localparam int DLW   = 2 * DVW + 2;     // delta, signed
    localparam int SQW   = 2 * DVW;         // square root operand
    localparam int RW    = SQW / 2;
    localparam int TW    = DVW + 1;         // t1 / t2
    localparam int ODW   = $bits(m_axis_tdata);
    localparam logic [W-2:0] MAXD = '1;

    // pipeline advances whenever the result register can take a new value
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    logic signed [W-1:0] r_cx, r_cy, r_cz;
    logic [W-2:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= (W-1)'(rsi_pkg::RADIUS_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                rsi_pkg::CFG_CENTER_X: r_cx     <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Y: r_cy     <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Z: r_cz     <= i_cfg_data;
                rsi_pkg::CFG_RADIUS:   r_radius <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // input field unpacking
    logic signed [W-1:0]  w_ox, w_oy, w_oz;
    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    assign w_ox = s_axis_tdata[W-1:0];
    assign w_oy = s_axis_tdata[2*W-1:W];
    assign w_oz = s_axis_tdata[3*W-1:2*W];
    assign w_dx = s_axis_tdata[3*W+DW-1:3*W];
    assign w_dy = s_axis_tdata[3*W+2*DW-1:3*W+DW];
    assign w_dz = s_axis_tdata[3*W+3*DW-1:3*W+2*DW];

    logic [6:1] r_vld;
    logic       w_in_xfer;
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:1], w_in_xfer};
        end
    end

    // stage 1: v = center - origin
    logic signed [VW-1:0] r_vx, r_vy, r_vz;
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    // stage 2: direction times v
    logic signed [PW-1:0] r_px, r_py, r_pz;
    // stage 3: dv
    logic signed [DVW-1:0] r_dv3, r_dv4, r_dv5, r_dv6;
    // stage 4 and 5: |v|^2
    logic [VSW-1:0] r_vs4, r_vs5;
    // stage 6: delta sign and magnitude
    logic           r_neg6;
    logic [SQW-1:0] r_rad6;

    logic [2*VW-1:0]  w_sqx, w_sqy, w_sqz, w_sqr;
    logic [2*DVW-1:0] w_sqdv;
    logic signed [AW-1:0]  w_acc;
    logic signed [DLW-1:0] w_delta;

    assign w_acc   = AW'(r_px) + AW'(r_py) + AW'(r_pz);
    assign w_delta = $signed(DLW'(w_sqdv)) + $signed(DLW'(w_sqr)) - $signed(DLW'(r_vs5));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vx  <= VW'(r_cx) - VW'(w_ox);
            r_vy  <= VW'(r_cy) - VW'(w_oy);
            r_vz  <= VW'(r_cz) - VW'(w_oz);
            r_dx  <= w_dx;
            r_dy  <= w_dy;
            r_dz  <= w_dz;
            r_px  <= r_dx * r_vx;
            r_py  <= r_dy * r_vy;
            r_pz  <= r_dz * r_vz;
            // floor division by 2^14
            r_dv3 <= w_acc[AW-1:rsi_pkg::DIR_FRAC];
            r_dv4 <= r_dv3;
            r_dv5 <= r_dv4;
            r_dv6 <= r_dv5;
            r_vs4 <= VSW'(w_sqx) + VSW'(w_sqy) + VSW'(w_sqz);
            r_vs5 <= r_vs4;
            r_neg6 <= w_delta[DLW-1];
            r_rad6 <= w_delta[DLW-1] ? '0 : w_delta[SQW-1:0];
        end
    end

    // squares of v (stages 2-3) and of dv (stages 4-5)
    rsi_square #(.WIDTH(VW)) u_sq_x (.i_clk(i_clk), .i_en(w_en), .i_a(r_vx), .o_sq(w_sqx));
    rsi_square #(.WIDTH(VW)) u_sq_y (.i_clk(i_clk), .i_en(w_en), .i_a(r_vy), .o_sq(w_sqy));
    rsi_square #(.WIDTH(VW)) u_sq_z (.i_clk(i_clk), .i_en(w_en), .i_a(r_vz), .o_sq(w_sqz));
    rsi_square #(.WIDTH(DVW)) u_sq_dv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_dv3),
        .o_sq  (w_sqdv)
    );
    // radius must change only while idle, which the block does not enforce; its square runs freely
    rsi_square #(.WIDTH(VW)) u_sq_r (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   ($signed({2'b00, r_radius})),
        .o_sq  (w_sqr)
    );

    // square root of delta, dv and the miss flag ride alongside
    logic                  w_sq_vld;
    logic [RW-1:0]         w_root;
    logic [DVW:0]          w_side;
    logic signed [DVW-1:0] w_dv;
    logic                  w_neg;

    rsi_sqrt #(.SQW(SQW), .SIDEW(DVW + 1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vld[6]),
        .i_rad   (r_rad6),
        .i_side  ({r_neg6, r_dv6}),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    assign w_neg = w_side[DVW];
    assign w_dv  = w_side[DVW-1:0];

    // near root first, far root if the near one is behind the origin
    logic signed [TW-1:0] w_t1, w_t2, w_t;
    logic                 w_hit;
    assign w_t1  = TW'(w_dv) - $signed(TW'(w_root));
    assign w_t2  = TW'(w_dv) + $signed(TW'(w_root));
    assign w_t   = !w_t1[TW-1] ? w_t1 : w_t2;
    assign w_hit = !w_neg && (!w_t1[TW-1] || !w_t2[TW-1]);

    logic         r_out_vld;
    logic         r_hit;
    logic [W-2:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_hit;
            if (!w_hit || (w_t > $signed(TW'(MAXD)))) begin
                r_dist <= MAXD;
            end else begin
                r_dist <= w_t[W-2:0];
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = ODW'(r_dist);

    // a miss always reports the saturated distance
    a_miss_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_hit) |-> (r_dist == MAXD))
        else $error("miss without maximum distance");

    // input is taken exactly when the result register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!r_out_vld || m_axis_tready))
        else $error("input ready out of step with output");

    // reset loads the unit radius
    a_rst_radius: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_radius == (W-1)'(rsi_pkg::RADIUS_RESET)))
        else $error("radius not reset");

    // a stalled pipeline moves no valid bit into the sqrt chain
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && i_rst_n) |=> $stable(r_vld))
        else $error("front stages moved during stall");

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// testbench for the ray / sphere intersection pipeline

class hit_scoreboard;
    logic [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0] radius;
    logic        want_hit[$];
    logic [30:0] want_dist[$];
    int          errors;

    function void reset_regs();
        ctr_x = '0;
        ctr_y = '0;
        ctr_z = '0;
        radius = 31'(rsi_pkg::RADIUS_RESET);
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
        case (idx)
            rsi_pkg::CFG_CENTER_X: ctr_x = val;
            rsi_pkg::CFG_CENTER_Y: ctr_y = val;
            rsi_pkg::CFG_CENTER_Z: ctr_z = val;
            rsi_pkg::CFG_RADIUS:   radius = val[30:0];
            default: ;
        endcase
    endfunction

    // integer square root, rounded down
    function logic [63:0] root_floor(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    // predicts the result of one accepted ray
    function void note_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
        logic signed [127:0] vx, vy, vz, acc, dv, delta, s, t;
        logic                hit;
        vx = $signed(ctr_x) - $signed(ox);
        vy = $signed(ctr_y) - $signed(oy);
        vz = $signed(ctr_z) - $signed(oz);
        acc = vx * $signed(dx) + vy * $signed(dy) + vz * $signed(dz);
        dv = acc >>> 14;
        delta = dv * dv + $signed({97'd0, radius}) * $signed({97'd0, radius})
                - vx * vx - vy * vy - vz * vz;
        hit = 1'b0;
        t = '0;
        if (delta >= 0) begin
            s = $signed({64'd0, root_floor(delta)});
            t = dv - s;
            if (t >= 0) hit = 1'b1;
            else begin
                t = dv + s;
                if (t >= 0) hit = 1'b1;
            end
        end
        want_hit.push_back(hit);
        if (!hit || t > 128'sh7fffffff) want_dist.push_back(31'h7fffffff);
        else want_dist.push_back(t[30:0]);
    endfunction

    function void check_result(logic got_hit, logic [30:0] got_dist);
        logic        eh;
        logic [30:0] ed;
        if (want_hit.size() == 0) begin
            $error("result with no ray outstanding");
            errors++;
            return;
        end
        eh = want_hit.pop_front();
        ed = want_dist.pop_front();
        if (got_hit !== eh) begin
            $error("hit_found expected %0d actual %0d", eh, got_hit);
            errors++;
        end
        if (got_dist !== ed) begin
            $error("hit_distance expected %0d actual %0d", ed, got_dist);
            errors++;
        end
    endfunction
endclass

module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    logic [143:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // hit_distance, zero fill
    logic [31:0] m_axis_tdata;
    // hit_found
    logic [0:0]  m_axis_tuser;

    hit_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    ray_sphere_intersection dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata[30:0]);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_cfg(logic [7:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    // one ray transfer, with a random gap ahead of it
    task automatic send_ray(logic [31:0] ox, oy, oz, logic [15:0] dx, dy, dz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dz, dy, dx, oz, oy, ox};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_ray(ox, oy, oz, dx, dy, dz);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.want_hit.size() != 0) @(posedge i_clk);
        repeat (rsi_pkg::COORD_WIDTH + 20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        endcase
    endfunction

    // origins mostly near the sphere so hits and misses both occur
    function automatic logic [31:0] rand_coord(logic [31:0] ctr);
        case ($urandom_range(3))
            0: return $urandom;
            1: return ctr + 32'($signed($urandom_range(32'h00100000)) - 32'sh00080000);
            default: return ctr + 32'($signed($urandom_range(32'h04000000)) - 32'sh02000000);
        endcase
    endfunction

    task automatic random_rays(int n);
        logic [15:0] dx, dy, dz;
        logic [31:0] ox, oy, oz;
        for (int k = 0; k < n; k++) begin
            ox = rand_coord(sb.ctr_x);
            oy = rand_coord(sb.ctr_y);
            oz = rand_coord(sb.ctr_z);
            dx = rand_dir();
            dy = rand_dir();
            dz = rand_dir();
            // aim roughly at the center for well-formed hit cases
            if ($urandom_range(1)) begin
                dx = 16'd0; dy = 16'd0; dz = 16'sd16384;
                ox = sb.ctr_x; oy = sb.ctr_y;
            end
            send_ray(ox, oy, oz, dx, dy, dz);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 77;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset sphere, unit radius at origin
        send_ray(32'hfffb0000, 0, 0, 16'sd16384, 0, 0);      // from outside, t1 = 4
        send_ray(0, 0, 0, 16'sd16384, 0, 0);                 // inside, t2 used
        send_ray(32'h00010000, 0, 0, 16'sd16384, 0, 0);      // on surface, leaving
        send_ray(32'hffff0000, 0, 0, 16'sd16384, 0, 0);      // on surface, t1 = 0
        send_ray(32'hfffb0000, 32'h00010000, 0, 16'sd16384, 0, 0); // tangent
        send_ray(32'h00050000, 0, 0, 16'sd16384, 0, 0);      // behind, miss
        send_ray(32'hfffb0000, 32'h00050000, 0, 16'sd16384, 0, 0); // miss
        send_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000, 16'hffff);
        send_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h7fff, 16'h0000);
        send_ray(0, 0, 0, 16'hffff, 16'hffff, 16'hffff);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, -16'sd16384, 0, 0);
        drain();

        // huge sphere, far hits saturate
        write_cfg(rsi_pkg::CFG_CENTER_X, 32'h7fffffff);
        write_cfg(rsi_pkg::CFG_CENTER_Y, 32'h80000000);
        write_cfg(rsi_pkg::CFG_CENTER_Z, 32'h7fffffff);
        write_cfg(rsi_pkg::CFG_RADIUS, 32'h7fffffff);
        write_cfg(8'd200, 32'h12345678);
        send_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 16'sd16384, 0, 0);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, 16'sd9459, 16'sd9459, 16'sd9459);
        send_ray(0, 0, 0, 0, 0, 0);
        random_rays(250);
        drain();

        // zero radius
        send_idle_pct = 77;
        recv_idle_pct = 28;
        write_cfg(rsi_pkg::CFG_CENTER_X, 32'h00030000);
        write_cfg(rsi_pkg::CFG_CENTER_Y, 32'hfffe0000);
        write_cfg(rsi_pkg::CFG_CENTER_Z, 32'h80000000);
        write_cfg(rsi_pkg::CFG_RADIUS, 32'h0);
        send_ray(32'h00030000, 32'hfffe0000, 32'h80010000, 0, 0, -16'sd16384);
        random_rays(150);
        drain();

        // moderate sphere, random settings
        write_cfg(rsi_pkg::CFG_CENTER_X, $urandom_range(32'h01000000));
        write_cfg(rsi_pkg::CFG_CENTER_Y, -$urandom_range(32'h01000000));
        write_cfg(rsi_pkg::CFG_CENTER_Z, $urandom);
        write_cfg(rsi_pkg::CFG_RADIUS, $urandom_range(32'h00400000, 32'h00010000));
        random_rays(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(rsi_pkg::CFG_CENTER_X, 32'h00100000);
        write_cfg(rsi_pkg::CFG_CENTER_Y, 32'h00200000);
        write_cfg(rsi_pkg::CFG_CENTER_Z, 32'hffe00000);
        write_cfg(rsi_pkg::CFG_RADIUS, 32'h00080000);
        random_rays(200);
        drain();
        random_rays(180);
        drain();

        if (sb.errors == 0 && sb.want_hit.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
rtl/rsi_pkg.sv
rtl/rsi_square.sv
rtl/rsi_sqrt.sv
rtl/ray_sphere_intersection.sv
sim/tb.sv
